// File: rtl/led_panel_scan_driver_defines.svh
// Assertion macros shared by the checker of the LED panel scan driver.
`ifndef LED_PANEL_SCAN_DRIVER_DEFINES_SVH
`define LED_PANEL_SCAN_DRIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPSD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lpsd: property violated");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPSD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpsd: property violated");

`endif

// File: rtl/lpsd_pkg.sv
// Types and constants shared by the LED panel scan driver modules.
package lpsd_pkg;

  localparam int XY_W        = 6;
  localparam int COLOR_W     = 3;
  localparam int ROW_W       = 5;
  localparam int ACTION_W    = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam int OUT_ROW_LSB = 6;
  localparam int OUT_ROW_MSB = 10;
  localparam int OUT_COL_LSB = 11;
  localparam int OUT_COL_MSB = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_SWAP  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_SWAP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic                 lower;
    logic [ROW_W-1:0]     row;
    logic [XY_W-1:0]      col;
    logic [COLOR_W-1:0]   color;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

// File: rtl/lpsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpsd_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lpsd_front.sv
// Front end: accepts requests, decodes them and drops those that do nothing.
module lpsd_front #(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [lpsd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic [lpsd_pkg::ACTION_W-1:0]        s_axis_tuser,
  input  logic                                 fifo_full_i,
  input  lpsd_pkg::back_stat_t                 stat_i,
  output logic                                 push_o,
  output lpsd_pkg::cmd_t                       cmd_o
);
  import lpsd_pkg::*;

  logic [XY_W-1:0]    x;
  logic [XY_W-1:0]    y;
  logic [COLOR_W-1:0] color;
  logic [7:0]         flip_row;
  logic               x_ok;
  logic               y_ok;
  logic               keep;

  assign x     = s_axis_tdata[XY_W-1:0];
  assign y     = s_axis_tdata[2*XY_W-1:XY_W];
  assign color = s_axis_tdata[2*XY_W+COLOR_W-1:2*XY_W];

  // Stored row is flipped; only rows 0..63 are ever shown.
  assign flip_row = 8'(PANEL_HEIGHT - 1) - 8'(y);
  assign x_ok     = 9'(x) < 9'(PANEL_WIDTH);
  assign y_ok     = 8'(y) < 8'(PANEL_HEIGHT);

  always_comb begin
    cmd_o       = '0;
    cmd_o.kind  = CMD_TICK;
    cmd_o.lower = flip_row[5];
    cmd_o.row   = flip_row[ROW_W-1:0];
    cmd_o.col   = x;
    cmd_o.color = color;
    keep        = 1'b0;
    case (s_axis_tuser)
      ACT_TICK: begin
        cmd_o.kind = CMD_TICK;
        keep       = 1'b1;
      end
      ACT_WRITE: begin
        cmd_o.kind = CMD_WRITE;
        keep       = x_ok && y_ok && (flip_row[7:6] == 2'b00);
      end
      ACT_SWAP: begin
        cmd_o.kind = CMD_SWAP;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = !fifo_full_i && !stat_i.clearing;
  assign push_o        = s_axis_tvalid && s_axis_tready && keep;

endmodule

// File: rtl/lpsd_cmd_fifo.sv
// Two-entry command queue between the front end and the scan engine.
module lpsd_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpsd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lpsd_pkg::cmd_t cmd_o
);
  import lpsd_pkg::*;

  localparam int Depth = 2;

  cmd_t       mem_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q == 2'(Depth);
  assign empty_o = count_q == 2'd0;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/lpsd_back.sv
// Scan engine: frame store, buffer swapping, row scanning and beat output.
module lpsd_back #(
  parameter int PANEL_WIDTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  lpsd_pkg::cmd_t                   cmd_i,
  output logic                             pop_o,
  output lpsd_pkg::back_stat_t             stat_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lpsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast
);
  import lpsd_pkg::*;

  localparam int CW    = $clog2(PANEL_WIDTH);
  localparam int AW    = 1 + ROW_W + CW;
  localparam int Depth = 2 ** AW;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_e;

  localparam logic [CW-1:0] LastCol = CW'(PANEL_WIDTH - 1);

  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [ROW_W-1:0]       row_q, row_d;
  logic                   sel_q, sel_d;
  logic                   pend_q, pend_d;
  logic [CW-1:0]          col_q, col_d;
  logic                   s1_valid_q, s1_valid_d;
  logic [ROW_W-1:0]       s1_row_q, s1_row_d;
  logic [XY_W-1:0]        s1_col_q, s1_col_d;
  logic                   s1_last_q, s1_last_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                   out_last_q, out_last_d;

  logic                   out_free;
  logic                   issue;
  logic                   clearing;
  logic                   wr_cmd;
  logic                   we_up;
  logic                   we_lo;
  logic [AW-1:0]          waddr;
  logic [COLOR_W-1:0]     wdata;
  logic [AW-1:0]          raddr;
  logic [COLOR_W-1:0]     up;
  logic [COLOR_W-1:0]     lo;

  assign clearing = state_q == ST_CLEAR;
  assign out_free = !out_valid_q || m_axis_tready;
  assign issue    = (state_q == ST_SCAN) && (!s1_valid_q || out_free);
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign wr_cmd   = pop_o && (cmd_i.kind == CMD_WRITE);
  assign we_up    = clearing || (wr_cmd && !cmd_i.lower);
  assign we_lo    = clearing || (wr_cmd && cmd_i.lower);
  assign waddr    = clearing ? clr_q : {~sel_q, cmd_i.row, CW'(cmd_i.col)};
  assign wdata    = clearing ? '0 : cmd_i.color;
  assign raddr    = {sel_q, row_q, col_q};

  lpsd_ram #(.WIDTH(COLOR_W), .DEPTH(Depth)) u_ram_upper (
    .clk_i   (clk_i),
    .we_i    (we_up),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (up)
  );

  lpsd_ram #(.WIDTH(COLOR_W), .DEPTH(Depth)) u_ram_lower (
    .clk_i   (clk_i),
    .we_i    (we_lo),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (lo)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    row_d       = row_q;
    sel_d       = sel_q;
    pend_d      = pend_q;
    col_d       = col_q;
    s1_valid_d  = s1_valid_q;
    s1_row_d    = s1_row_q;
    s1_col_d    = s1_col_q;
    s1_last_d   = s1_last_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_o) begin
          case (cmd_i.kind)
            CMD_SWAP: begin
              pend_d = 1'b1;
            end
            CMD_TICK: begin
              row_d = row_q + ROW_W'(1);
              if ((row_d == '0) && pend_q) begin
                sel_d  = ~sel_q;
                pend_d = 1'b0;
              end
              col_d   = '0;
              state_d = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          col_d = col_q + CW'(1);
          if (col_q == LastCol) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (issue) begin
      s1_valid_d = 1'b1;
      s1_row_d   = row_q;
      s1_col_d   = XY_W'(col_q);
      s1_last_d  = col_q == LastCol;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end

    if (out_free) begin
      out_valid_d = s1_valid_q;
      out_data_d  = {7'b0, s1_col_q, s1_row_q, lo[0], lo[1], lo[2], up[0], up[1], up[2]};
      out_last_d  = s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      row_q       <= '0;
      sel_q       <= 1'b1;
      pend_q      <= 1'b0;
      col_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_row_q    <= '0;
      s1_col_q    <= '0;
      s1_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      row_q       <= row_d;
      sel_q       <= sel_d;
      pend_q      <= pend_d;
      col_q       <= col_d;
      s1_valid_q  <= s1_valid_d;
      s1_row_q    <= s1_row_d;
      s1_col_q    <= s1_col_d;
      s1_last_q   <= s1_last_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_last_q  <= out_last_d;
    end
  end

  assign stat_o.clearing = clearing;
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tlast    = out_last_q;

endmodule

// File: rtl/led_panel_scan_driver.sv
// Top level of the LED panel scan driver: front end, command queue, scan engine.
//
// After reset the frame store is swept to zero, one entry of each half-store per
// cycle; no request is taken until the sweep ends. A scan tick is then taken from
// the queue by the scan engine, which sends one beat per cycle while m_axis_tready
// does not hold the output, as each frame store half has a single read port (rows
// r and r+32 live in separate memories and are read together). Pixel writes and
// swap requests are taken from the queue while the engine is idle. Beats leave
// through a two-stage read and output register pipeline. Rows below 64 of a
// taller panel are never shown and writes to them are dropped.
module led_panel_scan_driver #(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pixel_x[5:0], pixel_y[11:6], pixel_color[14:12], zero[15]
  input  logic [lpsd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [lpsd_pkg::ACTION_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // upper_red[0], upper_green[1], upper_blue[2], lower_red[3], lower_green[4],
  // lower_blue[5], row_address[10:6], column_index[16:11], zero[23:17]
  output logic [lpsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // last_beat
  output logic                             m_axis_tlast
);
  import lpsd_pkg::*;

  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  cmd_t       cmd_in;
  cmd_t       cmd_out;
  back_stat_t stat;

  lpsd_front #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .fifo_full_i   (full),
    .stat_i        (stat),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  lpsd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  lpsd_back #(.PANEL_WIDTH(PANEL_WIDTH)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .stat_o        (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: rtl/lpsd_checker.sv
// Port-level assertions for the LED panel scan driver and their bind.
`include "led_panel_scan_driver_defines.svh"

module lpsd_checker #(
  parameter int PANEL_WIDTH = 64
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lpsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);
  import lpsd_pkg::*;

  localparam logic [XY_W-1:0] LastCol = XY_W'(PANEL_WIDTH - 1);

  logic [XY_W-1:0]  col;
  logic [ROW_W-1:0] row;
  logic             beat;

  assign col  = m_axis_tdata[OUT_COL_MSB:OUT_COL_LSB];
  assign row  = m_axis_tdata[OUT_ROW_MSB:OUT_ROW_LSB];
  assign beat = m_axis_tvalid && m_axis_tready;

  `LPSD_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `LPSD_ASSERT_IMP(a_last_col, m_axis_tvalid, m_axis_tlast == (col == LastCol))
  `LPSD_ASSERT_NXT(a_col_step, beat && !m_axis_tlast, !m_axis_tvalid || ((col == $past(col) + XY_W'(1)) && (row == $past(row))))
  `LPSD_ASSERT_NXT(a_row_step, beat && m_axis_tlast, !m_axis_tvalid || ((col == '0) && (row == $past(row) + ROW_W'(1))))

endmodule

bind led_panel_scan_driver lpsd_checker #(.PANEL_WIDTH(PANEL_WIDTH)) u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
